>>> rtl/arm_fire_fault_interlock_sequencer_unit_defines.svh
// Assertion macros used by the checker file affis_checker.sv.
`ifndef ARM_FIRE_FAULT_INTERLOCK_SEQUENCER_UNIT_DEFINES_SVH
`define ARM_FIRE_FAULT_INTERLOCK_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AFFIS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define AFFIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/affis_pkg.sv
package affis_pkg;

	localparam int NUM_CHANNELS = 6;
	localparam logic [4:0] NUM_CH_LIM = 5'(NUM_CHANNELS);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_REQUIRED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_ENABLED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT_BYPASS    = 2'd2;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ARMED  = 2'd1;
	localparam logic [1:0] ST_FIRING = 2'd2;
	localparam logic [1:0] ST_FAULT  = 2'd3;

	localparam logic [3:0] ACT_ARM         = 4'd0;
	localparam logic [3:0] ACT_DISARM      = 4'd1;
	localparam logic [3:0] ACT_FIRE        = 4'd2;
	localparam logic [3:0] ACT_START_PLAIN = 4'd3;
	localparam logic [3:0] ACT_STOP        = 4'd4;
	localparam logic [3:0] ACT_SHOT_DONE   = 4'd5;
	localparam logic [3:0] ACT_POLL        = 4'd6;
	localparam logic [3:0] ACT_REP_OCP     = 4'd7;
	localparam logic [3:0] ACT_REP_ENOUT   = 4'd8;
	localparam logic [3:0] ACT_REP_BOARD   = 4'd9;
	localparam logic [3:0] ACT_REP_GENERAL = 4'd10;
	localparam logic [3:0] ACT_CLEAR       = 4'd11;

	localparam logic [2:0] FK_NONE    = 3'd0;
	localparam logic [2:0] FK_GENERAL = 3'd1;
	localparam logic [2:0] FK_OCP     = 3'd2;
	localparam logic [2:0] FK_ENOUT   = 3'd3;
	localparam logic [2:0] FK_BOARD   = 3'd4;
	localparam logic [2:0] FK_EXTEN   = 3'd5;

	localparam logic [3:0] DRV_NONE        = 4'd0;
	localparam logic [3:0] DRV_START_PROF  = 4'd1;
	localparam logic [3:0] DRV_START_PLAIN = 4'd2;
	localparam logic [3:0] DRV_GEN_RAMP    = 4'd3;
	localparam logic [3:0] DRV_CH_RAMP     = 4'd4;
	localparam logic [3:0] DRV_CH_DIS_STOP = 4'd5;
	localparam logic [3:0] DRV_STOP        = 4'd6;
	localparam logic [3:0] DRV_CH_DIS      = 4'd7;
	localparam logic [3:0] DRV_STOP_CLEAR  = 4'd8;

	localparam logic [1:0] LEG_NONE = 2'd0;
	localparam logic [1:0] LEG_SOFT = 2'd1;
	localparam logic [1:0] LEG_FULL = 2'd2;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_STATE     = 3'd1;
	localparam logic [2:0] EV_FAULT_IN  = 3'd2;
	localparam logic [2:0] EV_FAULT_CLR = 3'd3;
	localparam logic [2:0] EV_TRIGGER   = 3'd4;

	typedef struct packed {
		logic [3:0] action;
		logic [3:0] channel;
		logic       enable_level;
		logic       trigger_level;
		logic       outputs_ready;
		logic       profile_ok;
		logic       timer_fault;
		logic       driver_fault;
	} item_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [1:0] legacy_stop;
		logic [3:0] drive_channel;
		logic [3:0] drive_command;
		logic       channel_applies;
		logic [3:0] fault_channel;
		logic [2:0] fault_kind;
		logic [1:0] machine_state;
		logic       accepted;
	} res_t;

	function automatic logic per_channel(input logic [2:0] k);
		return (k == FK_OCP) || (k == FK_ENOUT) || (k == FK_BOARD);
	endfunction

endpackage

>>> rtl/affis_in_stage.sv
module affis_in_stage
	import affis_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic [3:0]  s_tuser,
	input  logic        advance,
	output logic        valid_s1,
	output item_t       item_s1
);

	logic take;

	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action        <= s_tuser;
			item_s1.channel       <= s_tdata[3:0];
			item_s1.enable_level  <= s_tdata[4];
			item_s1.trigger_level <= s_tdata[5];
			item_s1.outputs_ready <= s_tdata[6];
			item_s1.profile_ok    <= s_tdata[7];
			item_s1.timer_fault   <= s_tdata[8];
			item_s1.driver_fault  <= s_tdata[9];
		end
	end

endmodule

>>> rtl/affis_core.sv
module affis_core
	import affis_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_wdata,
	input  item_t                item,
	input  logic                 advance,
	output res_t                 res
);

	logic       enable_required_q;
	logic       trigger_enabled_q;
	logic       fault_bypass_q;

	logic [1:0] state_q;
	logic [2:0] kind_q;
	logic [3:0] fch_q;
	logic       base_q;

	logic [1:0] ns;
	logic [2:0] nk;
	logic [3:0] nch;
	logic       nbase;
	logic       lreq;
	logic [2:0] lkind;
	logic       latch;
	logic       en_ok;
	logic       ch_ok;
	logic [2:0] kind_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_required_q <= 1'b1;
			trigger_enabled_q <= 1'b1;
			fault_bypass_q    <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_ENABLE_REQUIRED: enable_required_q <= cfg_wdata;
				CFG_TRIGGER_ENABLED: trigger_enabled_q <= cfg_wdata;
				CFG_FAULT_BYPASS:    fault_bypass_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en_ok = !enable_required_q || item.enable_level;
	assign ch_ok = {1'b0, item.channel} < NUM_CH_LIM;

	always_comb begin
		ns    = state_q;
		nk    = kind_q;
		nch   = fch_q;
		nbase = base_q;
		lreq  = 1'b0;
		lkind = FK_GENERAL;
		res   = '0;
		case (item.action)
			ACT_ARM: begin
				if (state_q == ST_IDLE && en_ok && item.outputs_ready) begin
					ns            = ST_ARMED;
					nbase         = item.trigger_level;
					res.accepted  = 1'b1;
					res.event_res = EV_STATE;
				end
			end
			ACT_DISARM: begin
				if (state_q == ST_ARMED) begin
					ns            = ST_IDLE;
					res.event_res = EV_STATE;
				end
			end
			ACT_FIRE: begin
				if (state_q == ST_ARMED && en_ok && item.profile_ok) begin
					ns                = ST_FIRING;
					res.accepted      = 1'b1;
					res.drive_command = DRV_START_PROF;
					res.event_res     = EV_STATE;
				end
			end
			ACT_START_PLAIN: begin
				if (state_q == ST_ARMED && en_ok) begin
					ns                = ST_FIRING;
					res.accepted      = 1'b1;
					res.drive_command = DRV_START_PLAIN;
					res.event_res     = EV_STATE;
				end
			end
			ACT_STOP: begin
				if (state_q == ST_ARMED || state_q == ST_FIRING) begin
					ns            = ST_IDLE;
					res.event_res = EV_STATE;
				end
			end
			ACT_SHOT_DONE: begin
				if (state_q == ST_FIRING) begin
					ns            = ST_IDLE;
					res.event_res = EV_STATE;
				end
			end
			ACT_POLL: begin
				if (state_q != ST_FAULT) begin
					if (item.timer_fault || item.driver_fault) begin
						lreq  = 1'b1;
						lkind = FK_GENERAL;
					end else if (enable_required_q && state_q == ST_FIRING &&
							!item.enable_level) begin
						lreq  = 1'b1;
						lkind = FK_EXTEN;
					end
					// a bypassed fault does not latch and does not block the trigger edge below
					if (trigger_enabled_q && state_q == ST_ARMED &&
							!(lreq && !fault_bypass_q)) begin
						if (!base_q && item.trigger_level && en_ok && item.profile_ok) begin
							ns                = ST_FIRING;
							res.drive_command = DRV_START_PROF;
							res.event_res     = EV_TRIGGER;
						end
						nbase = item.trigger_level;
					end
				end
			end
			ACT_REP_OCP, ACT_REP_ENOUT, ACT_REP_BOARD: begin
				if (ch_ok) begin
					if (state_q == ST_FAULT) begin
						res.drive_command = DRV_CH_DIS;
						res.drive_channel = item.channel;
					end else begin
						lreq         = 1'b1;
						lkind        = (item.action == ACT_REP_OCP)   ? FK_OCP :
						               (item.action == ACT_REP_ENOUT) ? FK_ENOUT : FK_BOARD;
						res.accepted = !fault_bypass_q;
					end
				end
			end
			ACT_REP_GENERAL: begin
				if (state_q != ST_FAULT) begin
					lreq         = 1'b1;
					lkind        = FK_GENERAL;
					res.accepted = !fault_bypass_q;
				end
			end
			ACT_CLEAR: begin
				if (state_q == ST_FAULT) begin
					res.drive_command = DRV_STOP_CLEAR;
					if (!item.timer_fault && !item.driver_fault && en_ok) begin
						ns            = ST_IDLE;
						nk            = FK_NONE;
						nch           = 4'd0;
						res.accepted  = 1'b1;
						res.event_res = EV_FAULT_CLR;
					end
				end
			end
			default: ;
		endcase

		latch = lreq && !fault_bypass_q;
		if (latch) begin
			ns              = ST_FAULT;
			nk              = lkind;
			nch             = per_channel(lkind) ? item.channel : 4'd0;
			res.legacy_stop = (state_q == ST_FIRING) ? LEG_SOFT : LEG_FULL;
			if (per_channel(lkind)) begin
				res.drive_command = (state_q == ST_FIRING) ? DRV_CH_RAMP : DRV_CH_DIS_STOP;
				res.drive_channel = item.channel;
			end else begin
				res.drive_command = (state_q == ST_FIRING) ? DRV_GEN_RAMP : DRV_STOP;
				res.drive_channel = 4'd0;
			end
			res.event_res = EV_FAULT_IN;
		end

		kind_out            = (ns == ST_FAULT) ? nk : FK_NONE;
		res.machine_state   = ns;
		res.fault_kind      = kind_out;
		res.channel_applies = per_channel(kind_out);
		res.fault_channel   = per_channel(kind_out) ? nch : 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= FK_NONE;
			fch_q   <= 4'd0;
			base_q  <= 1'b0;
		end else if (advance) begin
			state_q <= ns;
			kind_q  <= nk;
			fch_q   <= nch;
			base_q  <= nbase;
		end
	end

endmodule

>>> rtl/affis_out_stage.sv
module affis_out_stage
	import affis_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  res_t        res,
	output logic        advance,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata
);

	res_t res_q;

	assign advance = valid_s1 && (!m_tvalid || m_tready);
	assign m_tdata = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

endmodule

>>> rtl/arm_fire_fault_interlock_sequencer_unit.sv
// m_tvalid rises once a transaction has passed the input register and the result register.
// One transaction per cycle unless the result stalls; state updates in the single decision stage.
// A stalled result holds while the input register still takes one more transaction.
// Reset (arst_n low, asynchronous): state idle, no fault, trigger baseline 0,
// enable_required 1, trigger_enabled 1, fault_bypass 0, both stages empty.
module arm_fire_fault_interlock_sequencer_unit
	import affis_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// channel[3:0], enable_level, trigger_level, outputs_ready, profile_ok,
	// timer_fault, driver_fault, zero pad[15:10]
	input  logic [15:0]          s_tdata,
	// action[3:0]
	input  logic [3:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// accepted, machine_state[2:1], fault_kind[5:3], fault_channel[9:6],
	// channel_applies[10], drive_command[14:11], drive_channel[18:15],
	// legacy_stop[20:19], event_res[23:21]
	output logic [23:0]          m_tdata
);

	logic  advance;
	logic  valid_s1;
	item_t item_s1;
	res_t  res;

	affis_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	affis_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item_s1),
		.advance   (advance),
		.res       (res)
	);

	affis_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.res      (res),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> rtl/affis_checker.sv
`include "arm_fire_fault_interlock_sequencer_unit_defines.svh"

module affis_checker
	import affis_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	res_t r;

	assign r = m_tdata;

	`AFFIS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
		"result dropped or changed while stalled")
	`AFFIS_ASSERT_NOW(a_kind_state, m_tvalid,
		(r.machine_state == ST_FAULT) == (r.fault_kind != FK_NONE),
		"fault kind disagrees with state")
	`AFFIS_ASSERT_NOW(a_applies, m_tvalid, r.channel_applies == per_channel(r.fault_kind),
		"channel flag disagrees with fault kind")
	`AFFIS_ASSERT_NOW(a_entry, m_tvalid && r.event_res == EV_FAULT_IN,
		r.machine_state == ST_FAULT && r.legacy_stop != LEG_NONE,
		"fault entry without fault state or stop")

endmodule

bind arm_fire_fault_interlock_sequencer_unit affis_checker u_chk (.*);

>>> verif/interlock_result_checker.sv
`timescale 1ns / 100ps

module interlock_result_checker
	import affis_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_wdata,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [15:0]          s_tdata,
	input  logic [3:0]           s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [23:0]          m_tdata,
	output int                   fail_count,
	output int                   results_owed
);

	logic       need_enable = 1'b1;
	logic       trig_on     = 1'b1;
	logic       bypass      = 1'b0;
	logic [1:0] seq_state   = ST_IDLE;
	logic [2:0] latched_kind = FK_NONE;
	logic [3:0] latched_ch  = '0;
	logic       trig_prev   = 1'b0;
	res_t       owed_q[$];
	int         n_fail      = 0;

	assign fail_count = n_fail;

	function automatic logic latch_fault(input logic [2:0] k, input logic [3:0] ch,
		inout res_t r);
		logic was_firing;
		logic per_ch;
		if (bypass)
			return 1'b0;
		was_firing = (seq_state == ST_FIRING);
		per_ch = k inside {FK_OCP, FK_ENOUT, FK_BOARD};
		seq_state = ST_FAULT;
		latched_kind = k;
		latched_ch = per_ch ? ch : 4'd0;
		r.legacy_stop = was_firing ? LEG_SOFT : LEG_FULL;
		if (per_ch) begin
			r.drive_command = was_firing ? DRV_CH_RAMP : DRV_CH_DIS_STOP;
			r.drive_channel = latched_ch;
		end else begin
			r.drive_command = was_firing ? DRV_GEN_RAMP : DRV_STOP;
			r.drive_channel = '0;
		end
		r.event_res = EV_FAULT_IN;
		return 1'b1;
	endfunction

	function automatic res_t interlock_step(input item_t it);
		res_t       r;
		logic [1:0] st;
		logic       en_ok;
		logic       ok;
		logic [2:0] k;
		r = '0;
		st = seq_state;
		en_ok = !need_enable || it.enable_level;
		case (it.action)
		ACT_ARM: if (st == ST_IDLE && en_ok && it.outputs_ready) begin
			seq_state = ST_ARMED;
			trig_prev = it.trigger_level;
			r.accepted = 1'b1;
			r.event_res = EV_STATE;
		end
		ACT_DISARM: if (st == ST_ARMED) begin
			seq_state = ST_IDLE;
			r.event_res = EV_STATE;
		end
		ACT_FIRE: if (st == ST_ARMED && en_ok && it.profile_ok) begin
			seq_state = ST_FIRING;
			r.accepted = 1'b1;
			r.drive_command = DRV_START_PROF;
			r.event_res = EV_STATE;
		end
		ACT_START_PLAIN: if (st == ST_ARMED && en_ok) begin
			seq_state = ST_FIRING;
			r.accepted = 1'b1;
			r.drive_command = DRV_START_PLAIN;
			r.event_res = EV_STATE;
		end
		ACT_STOP: if (st == ST_ARMED || st == ST_FIRING) begin
			seq_state = ST_IDLE;
			r.event_res = EV_STATE;
		end
		ACT_SHOT_DONE: if (st == ST_FIRING) begin
			seq_state = ST_IDLE;
			r.event_res = EV_STATE;
		end
		ACT_POLL: if (st != ST_FAULT) begin
			if (it.timer_fault || it.driver_fault)
				ok = latch_fault(FK_GENERAL, 4'd0, r);
			else if (need_enable && st == ST_FIRING && !it.enable_level)
				ok = latch_fault(FK_EXTEN, 4'd0, r);
			if (trig_on && seq_state == ST_ARMED) begin
				if (!trig_prev && it.trigger_level && en_ok && it.profile_ok) begin
					seq_state = ST_FIRING;
					r.drive_command = DRV_START_PROF;
					r.event_res = EV_TRIGGER;
				end
				trig_prev = it.trigger_level;
			end
		end
		ACT_REP_OCP, ACT_REP_ENOUT, ACT_REP_BOARD: if (it.channel < NUM_CHANNELS) begin
			if (st == ST_FAULT) begin
				r.drive_command = DRV_CH_DIS;
				r.drive_channel = it.channel;
			end else begin
				k = (it.action == ACT_REP_OCP) ? FK_OCP :
					(it.action == ACT_REP_ENOUT) ? FK_ENOUT : FK_BOARD;
				ok = latch_fault(k, it.channel, r);
				r.accepted = ok;
			end
		end
		ACT_REP_GENERAL: if (st != ST_FAULT) begin
			ok = latch_fault(FK_GENERAL, 4'd0, r);
			r.accepted = ok;
		end
		ACT_CLEAR: if (st == ST_FAULT) begin
			r.drive_command = DRV_STOP_CLEAR;
			if (!it.timer_fault && !it.driver_fault && en_ok) begin
				seq_state = ST_IDLE;
				latched_kind = FK_NONE;
				latched_ch = '0;
				r.accepted = 1'b1;
				r.event_res = EV_FAULT_CLR;
			end
		end
		default: ;
		endcase
		k = (seq_state == ST_FAULT) ? latched_kind : FK_NONE;
		r.machine_state = seq_state;
		r.fault_kind = k;
		r.channel_applies = k inside {FK_OCP, FK_ENOUT, FK_BOARD};
		r.fault_channel = r.channel_applies ? latched_ch : 4'd0;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [3:0] want,
		input logic [3:0] got);
		if (got !== want) begin
			n_fail++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t  want;
		res_t  got;
		item_t it;
		if (!arst_n) begin
			need_enable = 1'b1;
			trig_on = 1'b1;
			bypass = 1'b0;
			seq_state = ST_IDLE;
			latched_kind = FK_NONE;
			latched_ch = '0;
			trig_prev = 1'b0;
			owed_q.delete();
			results_owed <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
				CFG_ENABLE_REQUIRED: need_enable = cfg_wdata;
				CFG_TRIGGER_ENABLED: trig_on = cfg_wdata;
				CFG_FAULT_BYPASS: bypass = cfg_wdata;
				default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata);
				if (owed_q.size() == 0) begin
					n_fail++;
					$display("%0t ns: result with no transaction pending, expected none, actual %h",
						$time, m_tdata);
				end else begin
					want = owed_q.pop_front();
					check_field("accepted", 4'(want.accepted), 4'(got.accepted));
					check_field("machine_state", 4'(want.machine_state),
						4'(got.machine_state));
					check_field("fault_kind", 4'(want.fault_kind), 4'(got.fault_kind));
					check_field("fault_channel", want.fault_channel, got.fault_channel);
					check_field("channel_applies", 4'(want.channel_applies),
						4'(got.channel_applies));
					check_field("drive_command", want.drive_command, got.drive_command);
					check_field("drive_channel", want.drive_channel, got.drive_channel);
					check_field("legacy_stop", 4'(want.legacy_stop), 4'(got.legacy_stop));
					check_field("event_res", 4'(want.event_res), 4'(got.event_res));
				end
			end
			if (s_tvalid && s_tready) begin
				it.action = s_tuser;
				it.channel = s_tdata[3:0];
				it.enable_level = s_tdata[4];
				it.trigger_level = s_tdata[5];
				it.outputs_ready = s_tdata[6];
				it.profile_ok = s_tdata[7];
				it.timer_fault = s_tdata[8];
				it.driver_fault = s_tdata[9];
				owed_q.push_back(interlock_step(it));
			end
			results_owed <= owed_q.size();
		end
	end

endmodule

>>> verif/tb_arm_fire_fault_interlock_sequencer_unit.sv
`timescale 1ns / 100ps

module tb_arm_fire_fault_interlock_sequencer_unit;
	import affis_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_ITEMS = 210;
	localparam int LONG_HOLD = 150;
	localparam logic [3:0] ACT_UNUSED = 4'd15;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic                 cfg_wdata = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata = '0;
	logic [3:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [23:0]          m_tdata;
	int                   fail_count;
	int                   results_owed;
	logic                 long_stall = 1'b0;
	int                   burst_left = 0;
	int                   items_sent = 0;
	int                   idle_cycles = 0;

	// {enable_required, trigger_enabled, fault_bypass} per phase
	logic [2:0] phase_cfg [8] = '{3'b000, 3'b111, 3'b110, 3'b101,
		3'b011, 3'b100, 3'b010, 3'b001};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	arm_fire_fault_interlock_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	interlock_result_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	// pins: {enable, trigger, ready, profile_ok, timer_fault, driver_fault}
	function automatic item_t mk(input logic [3:0] act, input logic [3:0] ch,
		input logic [5:0] pins);
		item_t it;
		it.action = act;
		it.channel = ch;
		{it.enable_level, it.trigger_level, it.outputs_ready, it.profile_ok,
			it.timer_fault, it.driver_fault} = pins;
		return it;
	endfunction

	function automatic item_t clean_item(input logic [3:0] act);
		return mk(act, 4'($urandom_range(0, NUM_CHANNELS - 1)),
			{2'b10 | 2'($urandom_range(0, 1)), 4'b1100});
	endfunction

	function automatic item_t roughen(input item_t it);
		item_t r;
		r = it;
		if ($urandom_range(0, 99) < 8)
			r.enable_level = 1'b0;
		if ($urandom_range(0, 99) < 8)
			r.outputs_ready = 1'b0;
		if ($urandom_range(0, 99) < 10)
			r.profile_ok = 1'b0;
		if ($urandom_range(0, 99) < 6)
			r.timer_fault = 1'b1;
		if ($urandom_range(0, 99) < 6)
			r.driver_fault = 1'b1;
		if ($urandom_range(0, 99) < 10)
			r.channel = 4'($urandom_range(0, 15));
		return r;
	endfunction

	function automatic item_t wild_item();
		logic [15:0] b;
		b = 16'($urandom);
		return mk(b[3:0], b[7:4], b[13:8]);
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= it.action;
		s_tdata <= {6'b0, it.driver_fault, it.timer_fault, it.profile_ok,
			it.outputs_ready, it.trigger_level, it.enable_level, it.channel};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (results_owed != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [2:0] bits);
		write_reg(CFG_ENABLE_REQUIRED, bits[2]);
		write_reg(CFG_TRIGGER_ENABLED, bits[1]);
		write_reg(CFG_FAULT_BYPASS, bits[0]);
		cfg_wen <= 1'b0;
	endtask

	task automatic run_shot();
		item_t it;
		int    n;
		if ($urandom_range(0, 1) == 0)
			send_item(clean_item(ACT_STOP));
		send_item(roughen(clean_item(ACT_ARM)));
		case ($urandom_range(0, 4))
		0: send_item(roughen(clean_item(ACT_FIRE)));
		1: send_item(roughen(clean_item(ACT_START_PLAIN)));
		2, 3: begin
			it = clean_item(ACT_POLL);
			it.trigger_level = 1'b0;
			send_item(roughen(it));
			it.trigger_level = 1'b1;
			send_item(roughen(it));
		end
		default: send_item(roughen(clean_item(ACT_DISARM)));
		endcase
		n = $urandom_range(0, 4);
		repeat (n) send_item(roughen(clean_item(ACT_POLL)));
		case ($urandom_range(0, 5))
		0: send_item(roughen(clean_item(ACT_SHOT_DONE)));
		1: send_item(roughen(clean_item(ACT_STOP)));
		2, 3: begin
			send_item(roughen(clean_item(4'(ACT_REP_OCP + $urandom_range(0, 3)))));
			n = $urandom_range(0, 2);
			repeat (n) send_item(wild_item());
			send_item(roughen(clean_item(ACT_CLEAR)));
			send_item(clean_item(ACT_CLEAR));
		end
		4: begin
			it = clean_item(ACT_POLL);
			it.enable_level = 1'b0;
			send_item(it);
			send_item(roughen(clean_item(ACT_CLEAR)));
			send_item(clean_item(ACT_CLEAR));
		end
		default: send_item(wild_item());
		endcase
	endtask

	task automatic random_phase(input int quota);
		int start;
		start = items_sent;
		while (items_sent - start < quota) begin
			if ($urandom_range(0, 3) == 0)
				send_item(wild_item());
			else
				run_shot();
		end
	endtask

	// receiver
	initial begin
		int   mode;
		int   span;
		int   tick;
		logic hold_used;
		mode = 0;
		span = 0;
		tick = 0;
		hold_used = 1'b0;
		forever begin
			@(posedge clk);
			if (long_stall && !hold_used) begin
				hold_used = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!long_stall) begin
				hold_used = 1'b0;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 200);
			end
			span--;
			tick++;
			case (mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (tick % 3 != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apply_settings(3'b110);

		send_item(mk(ACT_CLEAR, 4'd0, 6'b101100));        // clear while idle
		send_item(mk(ACT_ARM, 4'd0, 6'b110100));          // outputs not ready
		send_item(mk(ACT_ARM, 4'd0, 6'b011100));          // enable low
		send_item(mk(ACT_ARM, 4'd0, 6'b111100));          // armed, trigger high
		send_item(mk(ACT_POLL, 4'd0, 6'b111100));         // level, no edge
		send_item(mk(ACT_POLL, 4'd0, 6'b101100));
		send_item(mk(ACT_POLL, 4'd0, 6'b111000));         // edge, profile fails
		send_item(mk(ACT_POLL, 4'd0, 6'b101100));
		send_item(mk(ACT_POLL, 4'd0, 6'b111100));         // trigger fires
		send_item(mk(ACT_REP_OCP, 4'd15, 6'b111100));     // channel out of range
		send_item(mk(ACT_REP_OCP, 4'd5, 6'b111100));      // ramp down while firing
		send_item(mk(ACT_REP_BOARD, 4'd2, 6'b111100));    // channel disable in fault
		send_item(mk(ACT_POLL, 4'd0, 6'b111111));
		send_item(mk(ACT_REP_GENERAL, 4'd0, 6'b111100));
		send_item(mk(ACT_CLEAR, 4'd0, 6'b101110));        // source still present
		send_item(mk(ACT_CLEAR, 4'd0, 6'b001100));        // enable low
		send_item(mk(ACT_CLEAR, 4'd0, 6'b101100));
		send_item(mk(ACT_UNUSED, 4'd15, 6'b111111));
		send_item(mk(ACT_ARM, 4'd0, 6'b101100));
		send_item(mk(ACT_FIRE, 4'd0, 6'b101000));         // profile not ok
		send_item(mk(ACT_START_PLAIN, 4'd0, 6'b101100));
		send_item(mk(ACT_POLL, 4'd0, 6'b001100));         // enable lost while firing
		send_item(mk(ACT_CLEAR, 4'd0, 6'b101100));
		send_item(mk(ACT_REP_ENOUT, 4'd0, 6'b101100));    // disable and stop from idle
		send_item(mk(ACT_CLEAR, 4'd0, 6'b101101));        // driver fault remains
		send_item(mk(ACT_CLEAR, 4'd0, 6'b101100));
		send_item(mk(ACT_ARM, 4'd0, 6'b101100));
		send_item(mk(ACT_FIRE, 4'd0, 6'b101100));
		send_item(mk(ACT_SHOT_DONE, 4'd0, 6'b101100));
		send_item(mk(ACT_ARM, 4'd0, 6'b101100));
		send_item(mk(ACT_DISARM, 4'd0, 6'b101100));
		wait_drained();

		foreach (phase_cfg[p]) begin
			apply_settings(phase_cfg[p]);
			if (p == 2)
				long_stall <= 1'b1;
			if (p == 4) begin
				random_phase(PHASE_ITEMS / 2);
				wait_drained();
				random_phase(PHASE_ITEMS / 2);
			end else begin
				random_phase(PHASE_ITEMS);
			end
			if (p == 2)
				long_stall <= 1'b0;
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/affis_pkg.sv
rtl/affis_in_stage.sv
rtl/affis_core.sv
rtl/affis_out_stage.sv
rtl/arm_fire_fault_interlock_sequencer_unit.sv
rtl/affis_checker.sv
verif/interlock_result_checker.sv
verif/tb_arm_fire_fault_interlock_sequencer_unit.sv
